FILE: src/rdq_pkg.sv
// Shared types, codes and constants of the reversible deque.
package rdq_pkg;

  localparam int WORD_W             = 32;
  localparam int OP_W               = 3;
  localparam int DEPTH_DEFAULT      = 64;
  localparam int DATA_WIDTH_DEFAULT = 32;
  localparam int CMD_FIFO_DEPTH     = 4;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
  localparam logic [OP_W-1:0] OP_TOGGLE     = 3'd4;
  localparam logic [OP_W-1:0] OP_LIST       = 3'd5;

  typedef enum logic [2:0] {
    K_NOP,
    K_PUSH,
    K_POP,
    K_TOGGLE,
    K_LIST
  } cmd_kind_t;

  // at_front refers to the logical front; the back part applies the reverse flag.
  typedef struct packed {
    cmd_kind_t         kind;
    logic              at_front;
    logic [WORD_W-1:0] value;
  } cmd_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP_OUT,
    S_LIST_RD,
    S_LIST_OUT
  } back_state_t;

endpackage

FILE: src/rdq_front.sv
// Front part: accepts input transfers and classifies them into commands.
module rdq_front (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [rdq_pkg::WORD_W-1:0] s_tdata,   // value
  input  logic [rdq_pkg::OP_W-1:0]   s_tuser,   // op
  input  logic                     fifo_full,
  output logic                     fifo_push,
  output rdq_pkg::cmd_t            fifo_cmd
);

  logic accept;

  always_comb begin
    fifo_cmd.kind     = rdq_pkg::K_NOP;
    fifo_cmd.at_front = 1'b0;
    fifo_cmd.value    = s_tdata;
    unique case (s_tuser) inside
      rdq_pkg::OP_PUSH_BACK, rdq_pkg::OP_PUSH_FRONT: begin
        fifo_cmd.kind     = rdq_pkg::K_PUSH;
        fifo_cmd.at_front = (s_tuser == rdq_pkg::OP_PUSH_FRONT);
      end
      rdq_pkg::OP_POP_FRONT, rdq_pkg::OP_POP_BACK: begin
        fifo_cmd.kind     = rdq_pkg::K_POP;
        fifo_cmd.at_front = (s_tuser == rdq_pkg::OP_POP_FRONT);
      end
      rdq_pkg::OP_TOGGLE: fifo_cmd.kind = rdq_pkg::K_TOGGLE;
      rdq_pkg::OP_LIST:   fifo_cmd.kind = rdq_pkg::K_LIST;
      default:            fifo_cmd.kind = rdq_pkg::K_NOP;
    endcase
  end

  assign s_tready  = !fifo_full;
  assign accept    = s_tvalid && s_tready;
  // Unused op codes are taken and dropped here, they never reach the back part.
  assign fifo_push = accept && (fifo_cmd.kind != rdq_pkg::K_NOP);

  // A NOP must never be queued.
  assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> fifo_cmd.kind != rdq_pkg::K_NOP)
    else $error("front queued an unused op code");

  assert property (@(posedge clk) disable iff (rst)
    fifo_push |-> !fifo_full)
    else $error("front pushed into a full command queue");

  assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready && s_tuser == rdq_pkg::OP_LIST) |-> fifo_push)
    else $error("list transfer was not queued");

endmodule

FILE: src/rdq_cmd_fifo.sv
// Short command queue between the front and the back part.
module rdq_cmd_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  rdq_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rdq_pkg::cmd_t head_cmd
);

  localparam int PW = $clog2(rdq_pkg::CMD_FIFO_DEPTH);

  rdq_pkg::cmd_t entries [rdq_pkg::CMD_FIFO_DEPTH];
  logic [PW:0]   wr_ptr;
  logic [PW:0]   rd_ptr;

  assign head_valid = (wr_ptr != rd_ptr);
  assign full       = (wr_ptr[PW-1:0] == rd_ptr[PW-1:0]) && (wr_ptr[PW] != rd_ptr[PW]);
  assign head_cmd   = entries[rd_ptr[PW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (push && !full) wr_ptr <= wr_ptr + 1'b1;
      if (pop && head_valid) rd_ptr <= rd_ptr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) entries[wr_ptr[PW-1:0]] <= push_cmd;
  end

endmodule

FILE: src/rdq_back.sv
// Back part: ring store, head and count, reverse flag, list sequencer and output register.
module rdq_back #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cmd_valid,
  input  rdq_pkg::cmd_t              cmd,
  output logic                       cmd_pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rdq_pkg::WORD_W-1:0] m_tdata,
  output logic                       m_tuser,
  output logic                       m_tlast
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam int WW = rdq_pkg::WORD_W;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] rd_data;

  rdq_pkg::back_state_t state, state_next;
  logic [AW-1:0] head, head_next;
  logic [CW-1:0] count, count_next;
  logic [CW-1:0] idx, idx_next;
  logic          rev, rev_next;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  out_load, out_empty_next, out_last_next;
  logic [WW-1:0]         out_word_next;
  logic                  out_free, phys_front, full_q;
  logic [AW-1:0]         head_dec, head_inc, slot_tail, slot_last, slot_list;
  logic [CW-1:0]         list_pos, idx_inc;
  logic [WW+DATA_WIDTH-1:0] value_ext, rd_ext;

  function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= (AW + 1)'(DEPTH)) s = s - (AW + 1)'(DEPTH);
    return s[AW-1:0];
  endfunction

  assign out_free   = !m_tvalid || m_tready;
  assign phys_front = cmd.at_front ^ rev;
  assign full_q     = (count == CW'(DEPTH));
  assign head_dec   = (head == '0) ? AW'(DEPTH - 1) : head - 1'b1;
  assign head_inc   = wrap_add(head, AW'(1));
  assign slot_tail  = wrap_add(head, count[AW-1:0]);
  assign slot_last  = wrap_add(head, AW'(count - 1'b1));
  assign list_pos   = rev ? (count - 1'b1 - idx) : idx;
  assign slot_list  = wrap_add(head, list_pos[AW-1:0]);
  assign idx_inc    = idx + 1'b1;

  // Between the 32-bit word and the stored width, values are zero-extended or truncated as the widths demand.
  assign value_ext  = {{DATA_WIDTH{1'b0}}, cmd.value};
  assign rd_ext     = {{WW{1'b0}}, rd_data};
  assign mem_wdata  = value_ext[DATA_WIDTH-1:0];

  always_comb begin
    state_next     = state;
    head_next      = head;
    count_next     = count;
    idx_next       = idx;
    rev_next       = rev;
    mem_we         = 1'b0;
    mem_waddr      = slot_tail;
    mem_re         = 1'b0;
    mem_raddr      = slot_list;
    cmd_pop        = 1'b0;
    out_load       = 1'b0;
    out_word_next  = rd_ext[WW-1:0];
    out_empty_next = 1'b0;
    out_last_next  = 1'b1;
    unique case (state)
      rdq_pkg::S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.kind)
            rdq_pkg::K_PUSH: begin
              cmd_pop = 1'b1;
              if (!full_q) begin
                mem_we     = 1'b1;
                count_next = count + 1'b1;
                if (phys_front) begin
                  mem_waddr = head_dec;
                  head_next = head_dec;
                end
              end
            end
            rdq_pkg::K_TOGGLE: begin
              cmd_pop  = 1'b1;
              rev_next = !rev;
            end
            rdq_pkg::K_POP, rdq_pkg::K_LIST: begin
              if (count == '0) begin
                // Empty queue: a single empty notice, once the output is free.
                if (out_free) begin
                  cmd_pop        = 1'b1;
                  out_load       = 1'b1;
                  out_word_next  = '0;
                  out_empty_next = 1'b1;
                end
              end else if (cmd.kind == rdq_pkg::K_POP) begin
                cmd_pop    = 1'b1;
                mem_re     = 1'b1;
                count_next = count - 1'b1;
                if (phys_front) begin
                  mem_raddr = head;
                  head_next = head_inc;
                end else begin
                  mem_raddr = slot_last;
                end
                state_next = rdq_pkg::S_POP_OUT;
              end else begin
                idx_next   = '0;
                state_next = rdq_pkg::S_LIST_RD;
              end
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      rdq_pkg::S_POP_OUT: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = rdq_pkg::S_IDLE;
        end
      end
      rdq_pkg::S_LIST_RD: begin
        mem_re     = 1'b1;
        state_next = rdq_pkg::S_LIST_OUT;
      end
      rdq_pkg::S_LIST_OUT: begin
        out_last_next = (idx_inc == count);
        if (out_free) begin
          out_load = 1'b1;
          if (idx_inc == count) begin
            // The list command leaves the queue only after its final word.
            cmd_pop    = 1'b1;
            state_next = rdq_pkg::S_IDLE;
          end else begin
            idx_next   = idx_inc;
            state_next = rdq_pkg::S_LIST_RD;
          end
        end
      end
      default: state_next = rdq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rdq_pkg::S_IDLE;
      head  <= '0;
      count <= '0;
      idx   <= '0;
      rev   <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      idx   <= idx_next;
      rev   <= rev_next;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= out_word_next;
      m_tuser <= out_empty_next;
      m_tlast <= out_last_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) count <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  assert property (@(posedge clk) disable iff (rst)
    (state == rdq_pkg::S_LIST_RD || state == rdq_pkg::S_LIST_OUT) |-> count != '0 && idx < count)
    else $error("list sequencer outside the stored words");

  assert property (@(posedge clk) disable iff (rst)
    (state == rdq_pkg::S_IDLE && cmd_valid && cmd.kind == rdq_pkg::K_POP && count != '0)
      |=> count == $past(count) - 1'b1 && state == rdq_pkg::S_POP_OUT)
    else $error("pop did not remove one word");

  assert property (@(posedge clk) disable iff (rst) out_load |-> out_free)
    else $error("output register overwritten while a result waits");

endmodule

FILE: src/reversible_deque_core.sv
// Top level of the reversible double-ended queue.
//
//  Channel  Dir  Signals                          Meaning
//  s_*      in   tvalid tready tdata tuser       one operation: tuser op, tdata value
//  m_*      out  tvalid tready tdata tuser tlast one result: word, empty notice, last
//
// Pushes and reverse toggles complete at one per cycle while the back part is idle; a push writes
// the ring store. A pop or a list reads the registered read port of the ring store into the output
// register, word by word for a list, once it is free; an empty notice is loaded there directly.
// Reset (synchronous, rst high) empties the queue and clears the reverse flag at once.
// The command queue lets input transfers continue while the output is stalled, until it fills.
module reversible_deque_core #(
  parameter int DEPTH      = rdq_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = rdq_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  input  logic [rdq_pkg::WORD_W-1:0] s_tdata,   // [31:0] value
  input  logic [rdq_pkg::OP_W-1:0]   s_tuser,   // [2:0] op
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic [rdq_pkg::WORD_W-1:0] m_tdata,   // [31:0] word
  output logic                       m_tuser,   // [0] empty_notice
  output logic                       m_tlast
);

  logic          fifo_full, fifo_push, fifo_pop, head_valid;
  rdq_pkg::cmd_t push_cmd, head_cmd;

  rdq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .fifo_full (fifo_full),
    .fifo_push (fifo_push),
    .fifo_cmd  (push_cmd)
  );

  rdq_cmd_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (fifo_push),
    .push_cmd   (push_cmd),
    .full       (fifo_full),
    .pop        (fifo_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  rdq_back #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (fifo_pop),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

endmodule
